>>> rtl/cpfb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpfb_pkg
// Shared types and constants of the clipped pixel format blit.
// ----------------------------------------------------------------------------
package cpfb_pkg;

    // field widths
    localparam int CHAN_W     = 8;
    localparam int NUM_CHAN   = 4;
    localparam int PIXEL_W    = 32;
    localparam int DIM_W      = 13;
    localparam int ORG_W      = 12;
    localparam int BPP_W      = 3;
    localparam int LEN_W      = 4;
    localparam int OFF_W      = 5;
    localparam int ADDR_W     = 26;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 40;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_LENGTHS = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_OFFSETS = 3'd7;

    // register reset values
    localparam logic [DIM_W-1:0]         RST_SCREEN_WIDTH  = 13'd4096;
    localparam logic [DIM_W-1:0]         RST_SCREEN_HEIGHT = 13'd4096;
    localparam logic [DIM_W-1:0]         RST_IMAGE_WIDTH   = 13'd1;
    localparam logic [BPP_W-1:0]         RST_BPP           = 3'd4;
    localparam logic [NUM_CHAN*LEN_W-1:0] RST_LENGTHS      = 16'h8888;
    localparam logic [NUM_CHAN*OFF_W-1:0] RST_OFFSETS      = 20'hC0110;

    // controller to datapath commands
    typedef struct packed {
        logic load;   // capture pixel, test clip, advance counters
        logic base;   // form start address and packed pixel word
        logic step;   // move to next byte write
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic keep;       // pixel lies on screen
        logic bpp_zero;   // no byte writes per pixel
        logic last_byte;  // current byte ends the pixel
    } t_sts;

    // cut a channel to its top len bits and shift it to its offset
    function automatic logic [PIXEL_W-1:0] pack_channel(
        input logic [CHAN_W-1:0] value,
        input logic [LEN_W-1:0]  len,
        input logic [OFF_W-1:0]  off
    );
        logic [LEN_W-1:0]  l;
        logic [LEN_W-1:0]  sh;
        logic [CHAN_W-1:0] v;
        l  = (len > 4'd8) ? 4'd8 : len;
        sh = 4'd8 - l;
        v  = value >> sh;
        return PIXEL_W'(v) << off;
    endfunction

endpackage
`default_nettype wire

>>> rtl/cpfb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpfb_ctrl
// Sequencer: accepts one pixel, lets the datapath form the address, then
// issues the byte write transactions of a kept pixel one at a time.
// ----------------------------------------------------------------------------
module cpfb_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_tvalid,
    input  wire logic            i_m_tready,
    input  wire cpfb_pkg::t_sts  i_sts,
    output cpfb_pkg::t_cmd       o_cmd,
    output logic                 o_s_tready,
    output logic                 o_m_tvalid
);
    import cpfb_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_BASE = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) n_state = S_BASE;
            end
            S_BASE: begin
                if (i_sts.keep && !i_sts.bpp_zero) n_state = S_EMIT;
                else n_state = S_IDLE;
            end
            S_EMIT: begin
                if (i_m_tready && i_sts.last_byte) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // handshakes and commands
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = (r_state == S_EMIT);
    assign o_cmd.load = (r_state == S_IDLE) && i_s_tvalid;
    assign o_cmd.base = (r_state == S_BASE);
    assign o_cmd.step = (r_state == S_EMIT) && i_m_tready;

endmodule
`default_nettype wire

>>> rtl/cpfb_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpfb_datapath
// Configuration registers, image position counters, clip test, address
// multiply and the pixel word that is shifted out a byte at a time.
// ----------------------------------------------------------------------------
module cpfb_datapath #(
    parameter int MAX_DIM   = 4096,
    parameter int MAX_BYTES = 4
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    input  wire logic                                        i_cfg_we,
    input  wire logic [cpfb_pkg::CFG_IDX_W-1:0]              i_cfg_index,
    input  wire logic [cpfb_pkg::CFG_DATA_W-1:0]             i_cfg_data,
    input  wire logic [cpfb_pkg::NUM_CHAN*cpfb_pkg::CHAN_W-1:0] i_chan,
    input  wire logic                                        i_image_end,
    input  wire cpfb_pkg::t_cmd                              i_cmd,
    output cpfb_pkg::t_sts                                   o_sts,
    output logic [cpfb_pkg::ADDR_W-1:0]                      o_byte_address,
    output logic [cpfb_pkg::CHAN_W-1:0]                      o_byte_value,
    output logic                                             o_pixel_done
);
    import cpfb_pkg::*;

    localparam int CW = $clog2(MAX_DIM);
    localparam int RW = $clog2(MAX_DIM + 1);
    localparam int BW = $clog2(MAX_BYTES + 1);
    localparam int XW = ((CW > ORG_W) ? CW : ORG_W) + 1;
    localparam int YW = ((RW > ORG_W) ? RW : ORG_W) + 1;
    localparam int KW = (XW > YW) ? XW : YW;
    localparam int PW = YW + DIM_W;
    localparam int EW = ((CW + 1) > DIM_W) ? (CW + 1) : DIM_W;
    localparam int MW = ADDR_W + BW;

    // configuration registers
    logic [DIM_W-1:0]          r_sw;
    logic [DIM_W-1:0]          r_sh;
    logic [DIM_W-1:0]          r_iw;
    logic [ORG_W-1:0]          r_ox;
    logic [ORG_W-1:0]          r_oy;
    logic [BPP_W-1:0]          r_bpp;
    logic [NUM_CHAN*LEN_W-1:0] r_len;
    logic [NUM_CHAN*OFF_W-1:0] r_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw  <= RST_SCREEN_WIDTH;
            r_sh  <= RST_SCREEN_HEIGHT;
            r_iw  <= RST_IMAGE_WIDTH;
            r_ox  <= '0;
            r_oy  <= '0;
            r_bpp <= RST_BPP;
            r_len <= RST_LENGTHS;
            r_off <= RST_OFFSETS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SCREEN_WIDTH:    r_sw  <= i_cfg_data[DIM_W-1:0];
                REG_SCREEN_HEIGHT:   r_sh  <= i_cfg_data[DIM_W-1:0];
                REG_IMAGE_WIDTH:     r_iw  <= i_cfg_data[DIM_W-1:0];
                REG_ORIGIN_X:        r_ox  <= i_cfg_data[ORG_W-1:0];
                REG_ORIGIN_Y:        r_oy  <= i_cfg_data[ORG_W-1:0];
                REG_BYTES_PER_PIXEL: r_bpp <= i_cfg_data[BPP_W-1:0];
                REG_CHANNEL_LENGTHS: r_len <= i_cfg_data[NUM_CHAN*LEN_W-1:0];
                REG_CHANNEL_OFFSETS: r_off <= i_cfg_data[NUM_CHAN*OFF_W-1:0];
                default: ;
            endcase
        end
    end

    // effective bytes per pixel, saturated
    logic [BW-1:0] bpp;
    assign bpp = (r_bpp > BPP_W'(MAX_BYTES)) ? BW'(MAX_BYTES) : BW'(r_bpp);

    // image position counters
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [CW:0]   col1;
    logic          wrap;

    assign col1 = {1'b0, r_col} + (CW + 1)'(1);
    assign wrap = (r_iw == '0) || (EW'(col1) >= EW'(r_iw))
               || (r_col == CW'(MAX_DIM - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.load) begin
            if (i_image_end) begin
                r_col <= '0;
                r_row <= '0;
            end else if (wrap) begin
                r_col <= '0;
                if (r_row < RW'(MAX_DIM)) r_row <= r_row + RW'(1);
            end else begin
                r_col <= col1[CW-1:0];
            end
        end
    end

    // screen position and clip test
    logic [XW-1:0] xsum;
    logic [YW-1:0] ysum;
    logic [PW-1:0] prod;
    logic          keep;

    assign xsum = XW'(r_col) + XW'(r_ox);
    assign ysum = YW'(r_row) + YW'(r_oy);
    assign keep = (KW'(r_ox) < KW'(r_sw)) && (KW'(r_oy) < KW'(r_sh))
               && (KW'(ysum) < KW'(r_sh)) && (KW'(xsum) < KW'(r_sw));
    assign prod = PW'(ysum) * PW'(r_sw);

    // capture pixel, clip result and pixel index
    logic [NUM_CHAN*CHAN_W-1:0] r_chan;
    logic                       r_keep;
    logic [ADDR_W-1:0]          r_pos;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_chan <= i_chan;
            r_keep <= keep;
            r_pos  <= ADDR_W'(prod + PW'(xsum));
        end
    end

    // packed pixel word
    logic [PIXEL_W-1:0] pixel;
    always_comb begin
        pixel = '0;
        for (int c = 0; c < NUM_CHAN; c++) begin
            pixel = pixel | pack_channel(r_chan[c*CHAN_W +: CHAN_W],
                                         r_len[c*LEN_W +: LEN_W],
                                         r_off[c*OFF_W +: OFF_W]);
        end
    end

    // byte write sequence
    logic [MW-1:0]      base_full;
    logic [ADDR_W-1:0]  r_addr;
    logic [PIXEL_W-1:0] r_pixel;
    logic [BW-1:0]      r_idx;
    logic [BW-1:0]      idx1;

    assign base_full = MW'(r_pos) * MW'(bpp);
    assign idx1      = r_idx + BW'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.base) begin
            r_addr  <= base_full[ADDR_W-1:0];
            r_pixel <= pixel;
            r_idx   <= '0;
        end else if (i_cmd.step) begin
            r_addr  <= r_addr + ADDR_W'(1);
            r_pixel <= r_pixel >> CHAN_W;
            r_idx   <= idx1;
        end
    end

    // status and output fields
    assign o_sts.keep      = r_keep;
    assign o_sts.bpp_zero  = (bpp == '0);
    assign o_sts.last_byte = (idx1 == bpp);

    assign o_byte_address = r_addr;
    assign o_byte_value   = r_pixel[CHAN_W-1:0];
    assign o_pixel_done   = (idx1 == bpp);

endmodule
`default_nettype wire

>>> rtl/clipped_pixel_format_blit.sv
`default_nettype none
// Sequence: a pixel is taken, its address is formed in the next cycle, and its
// first byte write is offered in the cycle after that.
// Pacing: a new pixel is taken only once the last one is done, and the output
// sequencer emits one byte per cycle while i_m_tready is high.
// Reset: synchronous active-low i_rst_n restores register defaults and clears
// the column and row counters.
// ----------------------------------------------------------------------------
// clipped_pixel_format_blit
// Places an RGBA8888 pixel stream into a framebuffer: clips against the
// screen, repacks the channels and emits little-endian byte writes.
// ----------------------------------------------------------------------------
module clipped_pixel_format_blit #(
    parameter int MAX_DIM   = 4096,
    parameter int MAX_BYTES = 4
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // configuration write channel
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [cpfb_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [cpfb_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // pixel input stream
    input  wire logic                                 i_s_tvalid,
    output logic                                      o_s_tready,
    input  wire logic [cpfb_pkg::IN_DATA_W-1:0]       i_s_tdata,  // red, green, blue, alpha
    input  wire logic                                 i_s_tlast,  // image_end
    // byte write stream
    output logic                                      o_m_tvalid,
    input  wire logic                                 i_m_tready,
    output logic [cpfb_pkg::OUT_DATA_W-1:0]           o_m_tdata,  // byte_address, byte_value, zero pad
    output logic                                      o_m_tlast   // pixel_done
);
    import cpfb_pkg::*;

    t_cmd              cmd;
    t_sts              sts;
    logic [ADDR_W-1:0] byte_address;
    logic [CHAN_W-1:0] byte_value;

    assign o_cfg_ready = 1'b1;

    cpfb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid)
    );

    cpfb_datapath #(
        .MAX_DIM   (MAX_DIM),
        .MAX_BYTES (MAX_BYTES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_chan         (i_s_tdata),
        .i_image_end    (i_s_tlast),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_byte_address (byte_address),
        .o_byte_value   (byte_value),
        .o_pixel_done   (o_m_tlast)
    );

    // pack output transaction fields
    assign o_m_tdata = {(OUT_DATA_W - ADDR_W - CHAN_W)'(0), byte_value, byte_address};

endmodule
`default_nettype wire

>>> tb/clipped_pixel_format_blit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// clipped_pixel_format_blit_tb
// Self-checking bench for the clipped pixel format blit. A clocked driver feeds
// RGBA pixels from a queue while a clocked monitor takes the byte writes and
// compares each one with the writes predicted for the accepted pixels. Runs a
// directed set of corner cases, a single-column image on a one-pixel-wide screen
// and random images under a series of random screen and pixel-format setups.
// ----------------------------------------------------------------------------
module clipped_pixel_format_blit_tb;
    import cpfb_pkg::*;

    localparam int MAX_DIM       = 4096;
    localparam int MAX_BYTES     = 4;
    localparam int COLUMN_RUN    = 20;
    localparam int RANDOM_PIXELS = 180;
    localparam int RANDOM_PHASES = 6;
    localparam int HOLD_CYCLES   = 250;
    localparam int SETTLE_CYCLES = 12;
    localparam int MAX_PRINTS    = 40;

    typedef struct packed {
        logic [CHAN_W-1:0] alpha;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
        logic              image_end;
    } t_pixel;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [CHAN_W-1:0] value;
        logic              done;
    } t_byte_write;

    // clock, reset and dut connections
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;

    // shadow copy of the registers and the position counters
    logic [DIM_W-1:0]          disp_width  = RST_SCREEN_WIDTH;
    logic [DIM_W-1:0]          disp_height = RST_SCREEN_HEIGHT;
    logic [DIM_W-1:0]          src_width   = RST_IMAGE_WIDTH;
    logic [ORG_W-1:0]          org_x       = '0;
    logic [ORG_W-1:0]          org_y       = '0;
    logic [BPP_W-1:0]          fb_bpp      = RST_BPP;
    logic [NUM_CHAN*LEN_W-1:0] chan_len    = RST_LENGTHS;
    logic [NUM_CHAN*OFF_W-1:0] chan_off    = RST_OFFSETS;
    logic [ORG_W-1:0]          col_pos     = '0;
    logic [DIM_W-1:0]          row_pos     = '0;

    t_pixel      pending_pixels[$];
    t_byte_write expected_writes[$];
    t_pixel      cur_pixel;

    logic no_gaps   = 1'b0;
    int   hold_reqs = 0;
    int   hold_seen = 0;
    int   hold_left = 0;

    int errors         = 0;
    int pixels_queued  = 0;
    int pixels_taken   = 0;
    int kept_pixels    = 0;
    int writes_checked = 0;
    int cfg_writes     = 0;

    clipped_pixel_format_blit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tlast   (s_tlast),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tlast   (m_tlast)
    );

    // 2 ns clock
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= MAX_PRINTS) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    // top len bits of a channel, moved up to its offset
    function automatic logic [PIXEL_W-1:0] place_channel(
        input logic [CHAN_W-1:0] value,
        input logic [LEN_W-1:0]  len,
        input logic [OFF_W-1:0]  off
    );
        int unsigned        keep_bits;
        logic [PIXEL_W-1:0] bits;
        keep_bits = (len > 4'd8) ? 8 : 32'(len);
        bits = PIXEL_W'(value);
        bits = bits >> (8 - keep_bits);
        return bits << off;
    endfunction

    // byte writes of one accepted pixel, then counter advance
    task automatic blit_pixel(input t_pixel px);
        int unsigned        wrap;
        int unsigned        nbytes;
        int unsigned        scr_col;
        int unsigned        scr_row;
        int unsigned        i;
        logic [PIXEL_W-1:0] word;
        logic [63:0]        first_addr;
        logic [63:0]        addr;
        t_byte_write        bw;
        wrap = (src_width == 0) ? 1 : 32'(src_width);
        if (wrap > MAX_DIM) begin
            wrap = MAX_DIM;
        end
        nbytes  = (fb_bpp > MAX_BYTES) ? MAX_BYTES : 32'(fb_bpp);
        scr_col = 32'(col_pos) + 32'(org_x);
        scr_row = 32'(row_pos) + 32'(org_y);
        if (32'(org_x) < 32'(disp_width) && 32'(org_y) < 32'(disp_height) &&
            scr_row < 32'(disp_height) && scr_col < 32'(disp_width)) begin
            word = place_channel(px.red,   chan_len[3:0],   chan_off[4:0])
                 | place_channel(px.green, chan_len[7:4],   chan_off[9:5])
                 | place_channel(px.blue,  chan_len[11:8],  chan_off[14:10])
                 | place_channel(px.alpha, chan_len[15:12], chan_off[19:15]);
            first_addr = (64'(scr_row) * 64'(disp_width) + 64'(scr_col)) * 64'(nbytes);
            kept_pixels++;
            for (i = 0; i < nbytes; i++) begin
                addr     = first_addr + 64'(i);
                bw.addr  = addr[ADDR_W-1:0];
                bw.value = word[8*i +: 8];
                bw.done  = (i == nbytes - 1);
                expected_writes.push_back(bw);
            end
        end
        if (px.image_end) begin
            col_pos = '0;
            row_pos = '0;
        end else if (32'(col_pos) + 1 >= wrap) begin
            col_pos = '0;
            if (row_pos < MAX_DIM) begin
                row_pos++;
            end
        end else begin
            col_pos++;
        end
    endtask

    task automatic check_write();
        t_byte_write want;
        if (expected_writes.size() == 0) begin
            report_mismatch($sformatf("unexpected byte write at 0x%07h",
                                      m_tdata[ADDR_W-1:0]));
        end else begin
            want = expected_writes.pop_front();
            writes_checked++;
            if (m_tdata[ADDR_W-1:0] !== want.addr) begin
                report_mismatch($sformatf("byte_address 0x%07h, want 0x%07h",
                                          m_tdata[ADDR_W-1:0], want.addr));
            end
            if (m_tdata[ADDR_W+CHAN_W-1:ADDR_W] !== want.value) begin
                report_mismatch($sformatf("byte_value 0x%02h at 0x%07h, want 0x%02h",
                                          m_tdata[ADDR_W+CHAN_W-1:ADDR_W], want.addr,
                                          want.value));
            end
            if (m_tlast !== want.done) begin
                report_mismatch($sformatf("pixel_done %b at 0x%07h, want %b",
                                          m_tlast, want.addr, want.done));
            end
        end
    endtask

    // pixel driver: predict on each accepted transaction, then offer the next
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                blit_pixel(cur_pixel);
                pixels_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_pixels.size() > 0 && (no_gaps || $urandom_range(99) >= 17)) begin
                    cur_pixel = pending_pixels.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {cur_pixel.alpha, cur_pixel.blue,
                                 cur_pixel.green, cur_pixel.red};
                    s_tlast  <= cur_pixel.image_end;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // byte write monitor with random backpressure and long hold-offs
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_write();
            end
            if (hold_reqs != hold_seen) begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= no_gaps || ($urandom_range(99) >= 17);
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_SCREEN_WIDTH:    disp_width  = value[DIM_W-1:0];
            REG_SCREEN_HEIGHT:   disp_height = value[DIM_W-1:0];
            REG_IMAGE_WIDTH:     src_width   = value[DIM_W-1:0];
            REG_ORIGIN_X:        org_x       = value[ORG_W-1:0];
            REG_ORIGIN_Y:        org_y       = value[ORG_W-1:0];
            REG_BYTES_PER_PIXEL: fb_bpp      = value[BPP_W-1:0];
            REG_CHANNEL_LENGTHS: chan_len    = value[NUM_CHAN*LEN_W-1:0];
            REG_CHANNEL_OFFSETS: chan_off    = value[NUM_CHAN*OFF_W-1:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    // all pixels taken and all writes seen, then let clipped pixels drain
    task automatic wait_idle();
        while (pixels_taken != pixels_queued || expected_writes.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic void queue_pixel(input int unsigned r, input int unsigned g,
                                        input int unsigned b, input int unsigned a,
                                        input logic last);
        t_pixel px;
        px.red       = r[7:0];
        px.green     = g[7:0];
        px.blue      = b[7:0];
        px.alpha     = a[7:0];
        px.image_end = last;
        pending_pixels.push_back(px);
        pixels_queued++;
    endfunction

    // one image in raster order; a broken one ends early or never marks its end
    function automatic void queue_image(input int unsigned w, input int unsigned h,
                                        input int unsigned flaw);
        int unsigned total;
        int unsigned i;
        total = w * h;
        if (flaw == 1) begin
            total = $urandom_range(1, total);
        end
        for (i = 0; i < total; i++) begin
            queue_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255),
                        $urandom_range(255), (flaw != 2) && (i == total - 1));
        end
    endfunction

    function automatic int unsigned pick_dim(input int unsigned common_hi);
        case ($urandom_range(15))
            0:       return 0;
            1:       return 1;
            2:       return MAX_DIM;
            3:       return 8191;
            default: return $urandom_range(2, common_hi);
        endcase
    endfunction

    function automatic int unsigned pick_origin();
        case ($urandom_range(7))
            0:       return 4095;
            1:       return $urandom_range(4095);
            default: return $urandom_range(0, 20);
        endcase
    endfunction

    task automatic pick_setup();
        write_reg(REG_SCREEN_WIDTH,    pick_dim(40));
        write_reg(REG_SCREEN_HEIGHT,   pick_dim(40));
        write_reg(REG_IMAGE_WIDTH,     pick_dim(12));
        write_reg(REG_ORIGIN_X,        pick_origin());
        write_reg(REG_ORIGIN_Y,        pick_origin());
        write_reg(REG_BYTES_PER_PIXEL,
                  ($urandom_range(4) == 0) ? $urandom_range(7) : $urandom_range(1, 4));
        write_reg(REG_CHANNEL_LENGTHS, $urandom_range(16'hFFFF));
        write_reg(REG_CHANNEL_OFFSETS, $urandom_range(20'hFFFFF));
    endtask

    // stimulus
    initial begin
        int          phase;
        int          phase_start;
        int unsigned i;
        int unsigned wrap;
        int unsigned img_w;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default setup: black, white, mixed pixel closing the image
        queue_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        queue_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        queue_pixel(8'hA5, 8'h5A, 8'hC3, 8'h3C, 1'b1);
        wait_idle();

        // small screen: column and row clip right at the edge, odd lengths
        write_reg(REG_SCREEN_WIDTH,    4);
        write_reg(REG_SCREEN_HEIGHT,   3);
        write_reg(REG_IMAGE_WIDTH,     3);
        write_reg(REG_ORIGIN_X,        2);
        write_reg(REG_ORIGIN_Y,        1);
        write_reg(REG_BYTES_PER_PIXEL, 3);
        write_reg(REG_CHANNEL_LENGTHS, 16'h3C05);
        write_reg(REG_CHANNEL_OFFSETS, (20 << 15) | (31 << 10) | (3 << 5));
        queue_image(3, 3, 0);
        wait_idle();

        // origin off screen in x, then in y, then a zero-width screen
        write_reg(REG_ORIGIN_X, 4);
        queue_image(2, 1, 0);
        wait_idle();
        write_reg(REG_ORIGIN_X, 0);
        write_reg(REG_ORIGIN_Y, 3);
        queue_image(2, 1, 0);
        wait_idle();
        write_reg(REG_SCREEN_WIDTH, 0);
        queue_pixel(8'h12, 8'h34, 8'h56, 8'h78, 1'b1);
        wait_idle();

        // far corner: address wrap, zero image width, bytes per pixel saturation
        write_reg(REG_SCREEN_WIDTH,    8191);
        write_reg(REG_SCREEN_HEIGHT,   8191);
        write_reg(REG_ORIGIN_X,        4095);
        write_reg(REG_ORIGIN_Y,        4095);
        write_reg(REG_IMAGE_WIDTH,     0);
        write_reg(REG_BYTES_PER_PIXEL, 7);
        write_reg(REG_CHANNEL_LENGTHS, 16'h8888);
        write_reg(REG_CHANNEL_OFFSETS, 0);
        queue_image(1, 2, 0);
        wait_idle();
        write_reg(REG_BYTES_PER_PIXEL, 0);
        queue_pixel(8'hFF, 8'h00, 8'hFF, 8'h00, 1'b1);
        wait_idle();
        write_reg(REG_BYTES_PER_PIXEL, 2);
        write_reg(REG_IMAGE_WIDTH,     8191);
        write_reg(REG_ORIGIN_X,        0);
        queue_image(2, 1, 2);
        wait_idle();

        // single-column image on a one-pixel-wide screen
        write_reg(REG_SCREEN_WIDTH,    1);
        write_reg(REG_ORIGIN_Y,        0);
        write_reg(REG_IMAGE_WIDTH,     1);
        write_reg(REG_BYTES_PER_PIXEL, 1);
        for (i = 0; i < COLUMN_RUN; i++) begin
            queue_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255),
                        $urandom_range(255), i == COLUMN_RUN - 1);
        end
        wait_idle();

        // random setups, mostly whole images, one phase under a long hold-off
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            pick_setup();
            if (phase == 2) begin
                // every pixel on screen so the hold-off backs up the input
                write_reg(REG_SCREEN_WIDTH,    MAX_DIM);
                write_reg(REG_SCREEN_HEIGHT,   MAX_DIM);
                write_reg(REG_ORIGIN_X,        0);
                write_reg(REG_ORIGIN_Y,        0);
                write_reg(REG_BYTES_PER_PIXEL, 4);
                no_gaps   <= 1'b1;
                hold_reqs <= hold_reqs + 1;
            end
            wrap = (src_width == 0) ? 1 : 32'(src_width);
            phase_start = pixels_queued;
            while (pixels_queued - phase_start < RANDOM_PIXELS / RANDOM_PHASES) begin
                img_w = (wrap <= 12) ? wrap : $urandom_range(1, 12);
                queue_image(img_w, $urandom_range(1, 4),
                            ($urandom_range(7) == 0) ? $urandom_range(1, 2) : 0);
            end
            wait_idle();
            no_gaps <= 1'b0;
        end

        $display("covered %0d pixels, %0d on screen, %0d byte writes checked, %0d reg writes",
                 pixels_taken, kept_pixels, writes_checked, cfg_writes);
        $display("incl. edge clipping, off-screen origins, address wrap and a long output stall");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // run limit
    initial begin
        #400000;
        $display("timeout after %0d pixels and %0d byte writes", pixels_taken, writes_checked);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
